FILE: sv/pwc_pkg.sv
package pwc_pkg;

	localparam int BANK_DEPTH = 64;
	localparam int IDX_W      = $clog2(BANK_DEPTH);
	localparam int CNT_W      = IDX_W + 1;
	localparam int WEIGHT_W   = 32;
	localparam int FRAC_W     = 16;
	localparam int TOT_W      = WEIGHT_W + IDX_W;
	localparam int TOOTH_W    = TOT_W + 1;
	localparam int MUL_W      = FRAC_W + TOT_W;
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int DIV_STEP_W = $clog2(TOT_W + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEETH     = 1'd1;

	localparam logic [CFG_W-1:0] THRESHOLD_RESET = 7'd64;
	localparam logic [CFG_W-1:0] TEETH_RESET     = 7'd64;

	typedef enum logic [3:0] {
		S_LOAD,
		S_DECIDE,
		S_PASS_RD,
		S_PASS_OUT,
		S_DIV,
		S_MUL,
		S_COMB_RD,
		S_COMB_ACC,
		S_COMB_EMIT,
		S_FINISH
	} state_t;

endpackage

FILE: sv/pwc_ram.sv
module pwc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/pwc_div.sv
module pwc_div import pwc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [TOT_W-1:0] dividend,
	input  logic [CFG_W-1:0] divisor,
	output logic             done,
	output logic [TOT_W-1:0] quotient
);

	// Restoring division, one quotient bit per cycle. The dividend shifts out
	// of the top of quo_q while quotient bits shift in at the bottom.
	logic [TOT_W-1:0]      quo_q;
	logic [CFG_W-1:0]      rem_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [CFG_W-1:0]      trial;
	logic                  ge;

	assign trial = {rem_q[CFG_W-2:0], quo_q[TOT_W-1]};
	assign ge    = (trial >= divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && run_q && (cnt_q == DIV_STEP_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_STEP_W'(TOT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_STEP_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[TOT_W-2:0], ge};
			rem_q <= ge ? (trial - divisor) : trial;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: sv/particle_weight_comb_top.sv
// A start in S_LOAD loads a weight; the last weight starts processing, during which busy is high.
// Pass-through: S_PASS_RD and S_PASS_OUT alternate after S_DECIDE, one result per S_PASS_OUT.
// Combing: a bit-serial divide and a multiply step, then S_COMB_RD, S_COMB_ACC and S_COMB_EMIT
// per slot plus one S_COMB_EMIT per tooth emitted; the single-port weight RAM sets the walk pace.
// Results are strobed for one cycle and the receiver cannot stall them.
// Asynchronous reset empties the bank and loads 64 into both configuration registers.
module particle_weight_comb_top import pwc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [WEIGHT_W-1:0]  weight_in,
	input  logic [FRAC_W-1:0]    rand_frac,
	input  logic                 last_in,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 strobe,
	output logic [IDX_W-1:0]     slot_index,
	output logic [WEIGHT_W-1:0]  weight_out,
	output logic                 combed,
	output logic                 last_out
);

	state_t state_q, state_d;

	logic [CFG_W-1:0]    thresh_q;
	logic [CFG_W-1:0]    teeth_q;
	logic [CNT_W-1:0]    fill_q;
	logic [TOT_W-1:0]    total_q;
	logic [FRAC_W-1:0]   rand_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    tcnt_q;
	logic [IDX_W-1:0]    cur_slot_q;
	logic [TOT_W-1:0]    avg_q;
	logic [TOT_W-1:0]    sum_q;
	logic [TOOTH_W-1:0]  tooth_q;

	logic                strobe_q;
	logic [IDX_W-1:0]    slot_q;
	logic [WEIGHT_W-1:0] wout_q;
	logic                combed_q;
	logic                last_q;

	logic                accept;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_addr;
	logic [WEIGHT_W-1:0] ram_rdata;
	logic                div_start;
	logic                div_done;
	logic [TOT_W-1:0]    div_quo;
	logic [CFG_W-1:0]    teeth_eff;
	logic                pass_cond;
	logic                comb_more;
	logic                hit;
	logic [MUL_W-1:0]    prod;
	logic [WEIGHT_W-1:0] avg_sat;

	pwc_ram #(
		.WIDTH (WEIGHT_W),
		.DEPTH (BANK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (weight_in),
		.rdata (ram_rdata)
	);

	pwc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_q),
		.divisor  (teeth_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		if (teeth_q == '0) begin
			teeth_eff = CFG_W'(1);
		end else if (teeth_q > CFG_W'(BANK_DEPTH)) begin
			teeth_eff = CFG_W'(BANK_DEPTH);
		end else begin
			teeth_eff = teeth_q;
		end
	end

	assign pass_cond = (fill_q < thresh_q) || (total_q == '0);
	assign comb_more = (idx_q != fill_q) && (tcnt_q != teeth_eff);
	assign hit       = ({1'b0, sum_q} > tooth_q) && (tcnt_q != teeth_eff);
	assign prod      = MUL_W'(rand_q) * MUL_W'(avg_q);
	assign avg_sat   = (avg_q[TOT_W-1:WEIGHT_W] != '0) ? '1 : avg_q[WEIGHT_W-1:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (accept && last_in) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE:    state_d = pass_cond ? S_PASS_RD : S_DIV;
			S_PASS_RD:   state_d = S_PASS_OUT;
			S_PASS_OUT:  state_d = (idx_q + 1'b1 == fill_q) ? S_FINISH : S_PASS_RD;
			S_DIV:       state_d = div_done ? S_MUL : S_DIV;
			S_MUL:       state_d = S_COMB_RD;
			S_COMB_RD:   state_d = comb_more ? S_COMB_ACC : S_FINISH;
			S_COMB_ACC:  state_d = S_COMB_EMIT;
			S_COMB_EMIT: state_d = hit ? S_COMB_EMIT : S_COMB_RD;
			S_FINISH:    state_d = S_LOAD;
			default:     state_d = S_LOAD;
		endcase
	end

	// Control outputs.
	always_comb begin
		busy      = (state_q != S_LOAD);
		accept    = start && (state_q == S_LOAD);
		ram_we    = accept && (fill_q != CNT_W'(BANK_DEPTH));
		ram_addr  = (state_q == S_LOAD) ? fill_q[IDX_W-1:0] : idx_q[IDX_W-1:0];
		div_start = (state_q == S_DECIDE) && !pass_cond;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			thresh_q <= THRESHOLD_RESET;
			teeth_q  <= TEETH_RESET;
			fill_q   <= '0;
			total_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == S_PASS_OUT) || ((state_q == S_COMB_EMIT) && hit);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_THRESHOLD: thresh_q <= cfg_data;
					CFG_TEETH:     teeth_q  <= cfg_data;
					default:       thresh_q <= thresh_q;
				endcase
			end
			if (ram_we) begin
				fill_q  <= fill_q + 1'b1;
				total_q <= total_q + TOT_W'(weight_in);
			end
			if (state_q == S_FINISH) begin
				fill_q  <= '0;
				total_q <= '0;
			end
		end
	end

	// Datapath and result registers.
	always_ff @(posedge clk) begin
		if (accept && last_in) begin
			rand_q <= rand_frac;
		end
		case (state_q)
			S_DECIDE: begin
				idx_q  <= '0;
				tcnt_q <= '0;
				sum_q  <= '0;
			end
			S_PASS_OUT: begin
				idx_q    <= idx_q + 1'b1;
				slot_q   <= idx_q[IDX_W-1:0];
				wout_q   <= ram_rdata;
				combed_q <= 1'b0;
				last_q   <= (idx_q + 1'b1 == fill_q);
			end
			S_DIV: begin
				if (div_done) begin
					avg_q <= div_quo;
				end
			end
			S_MUL: begin
				tooth_q <= TOOTH_W'(prod[MUL_W-1:FRAC_W]);
			end
			S_COMB_ACC: begin
				sum_q      <= sum_q + TOT_W'(ram_rdata);
				cur_slot_q <= idx_q[IDX_W-1:0];
				idx_q      <= idx_q + 1'b1;
			end
			S_COMB_EMIT: begin
				if (hit) begin
					tcnt_q   <= tcnt_q + 1'b1;
					tooth_q  <= tooth_q + TOOTH_W'(avg_q);
					slot_q   <= cur_slot_q;
					wout_q   <= avg_sat;
					combed_q <= 1'b1;
					last_q   <= (tcnt_q + 1'b1 == teeth_eff);
				end
			end
			default: begin
			end
		endcase
	end

	assign strobe     = strobe_q;
	assign slot_index = slot_q;
	assign weight_out = wout_q;
	assign combed     = combed_q;
	assign last_out   = last_q;

endmodule
